// ===== sv/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion that is switched off while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds while reset is high
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/dlr_pkg.sv =====
`default_nettype none
package dlr_pkg;

   // field widths
   localparam int LevelWidth    = 7;
   localparam int ReqLevelWidth = 8;
   localparam int DurWidth      = 24;
   localparam int CfgWidth      = 16;
   localparam int CsrIndexWidth = 2;
   localparam int StepWidth     = 4;
   localparam int DivCntWidth   = 5;
   localparam int ReqDataWidth  = 32;
   localparam int RspDataWidth  = 16;

   localparam logic [LevelWidth-1:0]  LevelMax     = 7'd100;
   localparam logic [DivCntWidth-1:0] DivLastCount = 5'd23;
   localparam logic [CfgWidth-1:0]    MinStepReset = 16'd20;
   localparam logic [CfgWidth-1:0]    InstantReset = 16'd50;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CsrMinStep = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrInstant = 2'd1;

   // item kinds
   localparam logic KindTick    = 1'b0;
   localparam logic KindRequest = 1'b1;

   // microprogram addresses
   localparam logic [StepWidth-1:0] StepWait     = 4'd0;
   localparam logic [StepWidth-1:0] StepDispatch = 4'd1;
   localparam logic [StepWidth-1:0] StepSame     = 4'd2;
   localparam logic [StepWidth-1:0] StepShort    = 4'd3;
   localparam logic [StepWidth-1:0] StepDivInit  = 4'd4;
   localparam logic [StepWidth-1:0] StepDivLoop  = 4'd5;
   localparam logic [StepWidth-1:0] StepRamp     = 4'd6;
   localparam logic [StepWidth-1:0] StepInstant  = 4'd7;
   localparam logic [StepWidth-1:0] StepTick     = 4'd8;
   localparam logic [StepWidth-1:0] StepEmit     = 4'd9;
   localparam logic [StepWidth-1:0] StepHold     = 4'd10;

   // datapath operations
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_RAMP_START,
      OP_INSTANT,
      OP_TICK,
      OP_EMIT
   } op_type;

   // jump conditions: jump when true, otherwise fall through
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_INPUT,
      COND_IS_TICK,
      COND_SAME_LEVEL,
      COND_SHORT_DUR,
      COND_DIV_BUSY,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      logic                 take;
      op_type               op;
      cond_type             cond;
      logic [StepWidth-1:0] target;
   } ctl_word_type;

   typedef struct packed {
      logic in_valid;
      logic is_tick;
      logic same_level;
      logic short_dur;
      logic div_busy;
      logic out_free;
   } dp_flags_type;

   // control store
   function automatic ctl_word_type micro_rom(input logic [StepWidth-1:0] step);
      ctl_word_type w;
      w = '{take: 1'b0, op: OP_NONE, cond: COND_ALWAYS, target: StepWait};
      unique case (step)
         StepWait:     w = '{1'b1, OP_LOAD,       COND_NO_INPUT,   StepWait};
         StepDispatch: w = '{1'b0, OP_NONE,       COND_IS_TICK,    StepTick};
         StepSame:     w = '{1'b0, OP_NONE,       COND_SAME_LEVEL, StepEmit};
         StepShort:    w = '{1'b0, OP_NONE,       COND_SHORT_DUR,  StepInstant};
         StepDivInit:  w = '{1'b0, OP_DIV_INIT,   COND_NEXT,       StepWait};
         StepDivLoop:  w = '{1'b0, OP_DIV_STEP,   COND_DIV_BUSY,   StepDivLoop};
         StepRamp:     w = '{1'b0, OP_RAMP_START, COND_ALWAYS,     StepEmit};
         StepInstant:  w = '{1'b0, OP_INSTANT,    COND_ALWAYS,     StepEmit};
         StepTick:     w = '{1'b0, OP_TICK,       COND_NEXT,       StepWait};
         StepEmit:     w = '{1'b0, OP_EMIT,       COND_OUT_FREE,   StepWait};
         StepHold:     w = '{1'b0, OP_NONE,       COND_ALWAYS,     StepEmit};
         default:      w = '{1'b0, OP_NONE,       COND_ALWAYS,     StepWait};
      endcase
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== sv/dlr_seq.sv =====
`default_nettype none
module dlr_seq (
   input  wire                         clock,
   input  wire                         reset,
   input  wire dlr_pkg::dp_flags_type  flags,
   output dlr_pkg::ctl_word_type       ctl
);

   logic [dlr_pkg::StepWidth-1:0] step_ff;
   logic [dlr_pkg::StepWidth-1:0] step_in;
   logic                          jump;

   // fetch control word
   assign ctl = dlr_pkg::micro_rom(step_ff);

   // evaluate jump condition
   always_comb begin
      unique case (ctl.cond)
         dlr_pkg::COND_NEXT:       jump = 1'b0;
         dlr_pkg::COND_ALWAYS:     jump = 1'b1;
         dlr_pkg::COND_NO_INPUT:   jump = !flags.in_valid;
         dlr_pkg::COND_IS_TICK:    jump = flags.is_tick;
         dlr_pkg::COND_SAME_LEVEL: jump = flags.same_level;
         dlr_pkg::COND_SHORT_DUR:  jump = flags.short_dur;
         dlr_pkg::COND_DIV_BUSY:   jump = flags.div_busy;
         dlr_pkg::COND_OUT_FREE:   jump = flags.out_free;
         default:                  jump = 1'b0;
      endcase
      step_in = jump ? ctl.target : step_ff + 1'b1;
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= dlr_pkg::StepWait;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/dlr_dp.sv =====
`default_nettype none
module dlr_dp (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire dlr_pkg::ctl_word_type           ctl,
   output dlr_pkg::dp_flags_type                flags,
   input  wire                                  req_tvalid,
   input  wire [dlr_pkg::ReqDataWidth-1:0]      req_tdata,
   input  wire                                  req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [dlr_pkg::RspDataWidth-1:0]     rsp_tdata,
   input  wire                                  csr_valid,
   input  wire [dlr_pkg::CsrIndexWidth-1:0]     csr_index,
   input  wire [dlr_pkg::CfgWidth-1:0]          csr_data
);

   localparam int LW = dlr_pkg::LevelWidth;
   localparam int DW = dlr_pkg::DurWidth;
   localparam int CW = dlr_pkg::CfgWidth;

   // configuration
   logic [CW-1:0]  min_step_ff, min_step_in;
   logic [CW-1:0]  instant_ff, instant_in;
   // latched item
   logic           kind_ff, kind_in;
   logic [LW-1:0]  req_lvl_ff, req_lvl_in;
   logic [DW-1:0]  dur_ff, dur_in;
   logic           changed_ff, changed_in;
   // ramp state
   logic [LW-1:0]  cur_ff, cur_in;
   logic [LW-1:0]  target_ff, target_in;
   logic           up_ff, up_in;
   logic [DW-1:0]  period_ff, period_in;
   logic [DW-1:0]  cd_ff, cd_in;
   logic           active_ff, active_in;
   logic [LW-1:0]  pos_ff, pos_in;
   // divider
   logic [LW-1:0]  dist_ff, dist_in;
   logic [LW-1:0]  rem_ff, rem_in;
   logic [DW-1:0]  quo_ff, quo_in;
   logic [dlr_pkg::DivCntWidth-1:0] div_cnt_ff, div_cnt_in;
   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [dlr_pkg::RspDataWidth-1:0] rsp_data_ff, rsp_data_in;

   logic [dlr_pkg::ReqLevelWidth-1:0] raw_lvl;
   logic [LW:0]    trial;
   logic           trial_ge;
   logic [LW:0]    trial_diff;
   logic [DW-1:0]  min_ext;
   logic [DW-1:0]  period_raw;
   logic [DW-1:0]  period_new;
   logic [DW-1:0]  cd_dec;
   logic           out_free;
   logic           accept;

   function automatic logic [LW-1:0] step_toward(input logic [LW-1:0] v, input logic up);
      logic [LW-1:0] r;
      r = v;
      if (up) begin
         if (v < dlr_pkg::LevelMax) r = v + 1'b1;
      end else begin
         if (v != '0) r = v - 1'b1;
      end
      return r;
   endfunction

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign accept   = (ctl.op == dlr_pkg::OP_LOAD) && req_tvalid;

   // status to the sequencer
   assign flags.in_valid   = req_tvalid;
   assign flags.is_tick    = (kind_ff == dlr_pkg::KindTick);
   assign flags.same_level = (req_lvl_ff == cur_ff);
   assign flags.short_dur  = (dur_ff < {{(DW-CW){1'b0}}, instant_ff});
   assign flags.div_busy   = (div_cnt_ff != '0);
   assign flags.out_free   = out_free;

   // incoming level field, clamped on load
   assign raw_lvl = req_tdata[dlr_pkg::ReqLevelWidth-1:0];

   // restoring divide step, one quotient bit per cycle
   assign trial      = {rem_ff, quo_ff[DW-1]};
   assign trial_ge   = (trial >= {1'b0, dist_ff});
   assign trial_diff = trial - {1'b0, dist_ff};

   // step period, raised to the floor and to at least one
   assign min_ext    = {{(DW-CW){1'b0}}, min_step_ff};
   assign period_raw = (quo_ff < min_ext) ? min_ext : quo_ff;
   assign period_new = (period_raw == '0) ? {{(DW-1){1'b0}}, 1'b1} : period_raw;

   assign cd_dec = (cd_ff != '0) ? cd_ff - 1'b1 : cd_ff;

   // datapath operations
   always_comb begin
      min_step_in  = min_step_ff;
      instant_in   = instant_ff;
      kind_in      = kind_ff;
      req_lvl_in   = req_lvl_ff;
      dur_in       = dur_ff;
      changed_in   = changed_ff;
      cur_in       = cur_ff;
      target_in    = target_ff;
      up_in        = up_ff;
      period_in    = period_ff;
      cd_in        = cd_ff;
      active_in    = active_ff;
      pos_in       = pos_ff;
      dist_in      = dist_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      // register writes
      if (csr_valid) begin
         if (csr_index == dlr_pkg::CsrMinStep) min_step_in = csr_data;
         if (csr_index == dlr_pkg::CsrInstant) instant_in  = csr_data;
      end

      unique case (ctl.op)
         dlr_pkg::OP_LOAD: begin
            if (accept) begin
               kind_in    = req_tuser;
               req_lvl_in = (raw_lvl > {1'b0, dlr_pkg::LevelMax}) ? dlr_pkg::LevelMax
                                                                   : raw_lvl[LW-1:0];
               dur_in     = req_tdata[dlr_pkg::ReqLevelWidth +: DW];
               changed_in = 1'b0;
            end
         end
         dlr_pkg::OP_DIV_INIT: begin
            target_in  = req_lvl_ff;
            up_in      = (req_lvl_ff > cur_ff);
            dist_in    = (req_lvl_ff > cur_ff) ? req_lvl_ff - cur_ff : cur_ff - req_lvl_ff;
            rem_in     = '0;
            quo_in     = dur_ff;
            div_cnt_in = dlr_pkg::DivLastCount;
         end
         dlr_pkg::OP_DIV_STEP: begin
            rem_in = trial_ge ? trial_diff[LW-1:0] : trial[LW-1:0];
            quo_in = {quo_ff[DW-2:0], trial_ge};
            if (div_cnt_ff != '0) div_cnt_in = div_cnt_ff - 1'b1;
         end
         dlr_pkg::OP_RAMP_START: begin
            period_in = period_new;
            cd_in     = period_new;
            pos_in    = step_toward(cur_ff, up_ff);
            active_in = 1'b1;
         end
         dlr_pkg::OP_INSTANT: begin
            cur_in     = req_lvl_ff;
            changed_in = 1'b1;
         end
         dlr_pkg::OP_TICK: begin
            if (active_ff) begin
               cd_in = cd_dec;
               if (cd_dec == '0) begin
                  changed_in = (cur_ff != pos_ff);
                  cur_in     = pos_ff;
                  if (pos_ff == target_ff) begin
                     active_in = 1'b0;
                  end else begin
                     pos_in = step_toward(pos_ff, up_ff);
                     cd_in  = period_ff;
                  end
               end
            end
         end
         dlr_pkg::OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(dlr_pkg::RspDataWidth-LW-2){1'b0}},
                               active_ff, changed_ff, cur_ff};
            end
         end
         default: begin
         end
      endcase
   end

   // control and ramp state
   always_ff @(posedge clock) begin
      if (reset) begin
         min_step_ff  <= dlr_pkg::MinStepReset;
         instant_ff   <= dlr_pkg::InstantReset;
         cur_ff       <= '0;
         target_ff    <= '0;
         up_ff        <= 1'b0;
         period_ff    <= '0;
         cd_ff        <= '0;
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_step_ff  <= min_step_in;
         instant_ff   <= instant_in;
         cur_ff       <= cur_in;
         target_ff    <= target_in;
         up_ff        <= up_in;
         period_ff    <= period_in;
         cd_ff        <= cd_in;
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      req_lvl_ff  <= req_lvl_in;
      dur_ff      <= dur_in;
      changed_ff  <= changed_in;
      dist_ff     <= dist_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== sv/dimmer_level_ramp_core.sv =====
`default_nettype none
// Linear dimmer ramp. Each request beat is a 1 ms tick or a new level request, and each
// gives exactly one response beat with the applied level, a changed flag and the ramp
// flag. A small microprogram in a control store steps a plain datapath; one item is
// worked at a time. A ramp start runs the bit-serial divider that computes the step
// period (one quotient bit per cycle). While the previous response is still held, a
// finished one waits in a hold step and retries the emit step. The user must write
// registers through the csr port only while the block is idle; the block itself does
// not enforce this. Writes then take effect on the next item; neither channel takes a
// beat while reset is high.
module dimmer_level_ramp_core (
   input  wire                                  clock,
   input  wire                                  reset,
   // request channel
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire [dlr_pkg::ReqDataWidth-1:0]      req_tdata,   // requested_level, duration_ms
   input  wire                                  req_tuser,   // req_type
   // response channel
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [dlr_pkg::RspDataWidth-1:0]     rsp_tdata,   // level, level_changed, ramping
   // register write channel
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire [dlr_pkg::CsrIndexWidth-1:0]     csr_index,
   input  wire [dlr_pkg::CfgWidth-1:0]          csr_data
);

   dlr_pkg::ctl_word_type ctl;
   dlr_pkg::dp_flags_type flags;

   assign req_tready = ctl.take && !reset;
   assign csr_ready  = !reset;

   // microprogram sequencer
   dlr_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   // datapath with divider and result register
   dlr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .flags      (flags),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

endmodule
`default_nettype wire

// ===== sv/dlr_chk.sv =====
`default_nettype none
`include "assert_macros.svh"
module dlr_chk (
   input wire                                clock,
   input wire                                reset,
   input wire                                req_tvalid,
   input wire                                req_tready,
   input wire                                rsp_tvalid,
   input wire                                rsp_tready,
   input wire [dlr_pkg::RspDataWidth-1:0]    rsp_tdata
);

   // reset empties the response register
   `ASSERT_CLK_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "response after reset")

   // one item in flight: no request beat right after one was taken
   `ASSERT_CLK(a_one_item, clock, reset, req_tvalid && req_tready |=> !req_tready, "second beat taken")

   // applied level never exceeds full brightness
   `ASSERT_CLK(a_level_range, clock, reset, rsp_tvalid |-> rsp_tdata[6:0] <= dlr_pkg::LevelMax, "level out of range")

   // stalled response holds its beat
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response dropped")

endmodule

bind dimmer_level_ramp_core dlr_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
